>>> sv/variable_width_crc_hash_defines.svh
// Assertion macros for the variable-width CRC hash block.
`ifndef VARIABLE_WIDTH_CRC_HASH_DEFINES_SVH
`define VARIABLE_WIDTH_CRC_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VWCH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vwch: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VWCH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vwch: next-cycle check failed");

`endif

>>> sv/vwch_pkg.sv
// Types, constants and width decode for the variable-width CRC hash.
package vwch_pkg;

	localparam int CRC_BITS        = 64;
	localparam int HASH_WIDTH_BITS = 7;
	localparam int SHIFT_BITS      = 6;

	localparam logic [CRC_BITS-1:0] CRC_SEED      = 64'hFAC4_32B1_0CD5_E44A;
	localparam logic [CRC_BITS-1:0] CRC_BASE_POLY = 64'h0060_0340_00F0_D50B;

	localparam logic [HASH_WIDTH_BITS-1:0] WIDTH_MIN = 7'd16;
	localparam logic [HASH_WIDTH_BITS-1:0] WIDTH_MAX = 7'd64;

	// Everything the datapath needs from the configured width.
	typedef struct packed {
		logic [CRC_BITS-1:0]   mask;
		logic [CRC_BITS-1:0]   poly;
		logic [SHIFT_BITS-1:0] shift;
	} vwch_settings_t;

	localparam vwch_settings_t RESET_SETTINGS = '{
		mask:  {CRC_BITS{1'b1}},
		poly:  CRC_BASE_POLY,
		shift: 6'd56
	};

	function automatic vwch_settings_t vwch_decode(input logic [HASH_WIDTH_BITS-1:0] hash_width);
		logic [HASH_WIDTH_BITS-1:0] n;
		vwch_settings_t s;
		n = hash_width;
		if (hash_width < WIDTH_MIN) n = WIDTH_MIN;
		if (hash_width > WIDTH_MAX) n = WIDTH_MAX;
		if (n == WIDTH_MAX) begin
			s.mask = {CRC_BITS{1'b1}};
			s.poly = CRC_BASE_POLY;
		end else begin
			s.mask = (64'd1 << n) - 64'd1;
			s.poly = (CRC_BASE_POLY >> (WIDTH_MAX - n)) | 64'd1;
		end
		s.shift = SHIFT_BITS'(n - 7'd8);
		return s;
	endfunction

endpackage

>>> sv/vwch_msg_if.sv
// Message byte channel: valid/ready handshake with byte, presence and end flag.
interface vwch_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;

	modport source (output valid, output data_byte, output byte_present, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input last,
		output ready);
endinterface

>>> sv/vwch_hash_if.sv
// Hash result channel: valid/ready handshake with the 64-bit hash in two halves.
interface vwch_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_high;
	logic [31:0] hash_low;

	modport source (output valid, output hash_high, output hash_low, input ready);
	modport sink (input valid, input hash_high, input hash_low, output ready);
endinterface

>>> sv/vwch_step.sv
// One byte of CRC update: top-byte select, table entry, shift and mask.
module vwch_step import vwch_pkg::*; (
	input  vwch_settings_t      settings,
	input  logic [CRC_BITS-1:0] crc,
	input  logic [7:0]          data_byte,
	output logic [CRC_BITS-1:0] crc_next
);

	logic [CRC_BITS-1:0] shifted;
	logic [7:0]          sel;
	logic [CRC_BITS-1:0] entry;

	always_comb begin
		shifted = crc >> settings.shift;
		sel     = shifted[7:0];
		// Table entry is linear in the selector: bit k adds poly shifted by k.
		entry = '0;
		for (int k = 0; k < 8; k++) begin
			if (sel[k]) entry = entry ^ (settings.poly << k);
		end
		crc_next = ((crc << 8) ^ {56'd0, data_byte} ^ entry) & settings.mask;
	end

endmodule

>>> sv/variable_width_crc_hash.sv
// Top level of the variable-width CRC hash (16 to 64 bit, byte at a time).
//
//   channel  dir  handshake      payload
//   msg      in   valid/ready    data_byte[7:0], byte_present, last
//   hash     out  valid/ready    hash_high[31:0], hash_low[31:0]
//   cfg      in   cfg_write      cfg_data[6:0] = hash_width
//
// One byte per cycle while no last item is held in the input stage: input stage register, CRC update, result register.
// The CRC update in the register loop (top-byte shift, entry xor, mask) is combinational.
// Reset and a width write both load the seed masked to the width; no clearing pass.
// A last item waits in the input stage only while the result register is full.

`include "variable_width_crc_hash_defines.svh"

module variable_width_crc_hash import vwch_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [HASH_WIDTH_BITS-1:0] cfg_data,
	vwch_msg_if.sink                   msg,
	vwch_hash_if.source                hash
);

	vwch_settings_t      settings_q;
	vwch_settings_t      cfg_settings;
	logic [CRC_BITS-1:0] crc_q;
	logic [CRC_BITS-1:0] crc_next;
	logic [CRC_BITS-1:0] crc_upd;

	logic                valid_s1;
	logic [7:0]          data_byte_s1;
	logic                present_s1;
	logic                last_s1;
	logic                adv_s1;

	logic                out_valid_q;
	logic [CRC_BITS-1:0] hash_q;

	vwch_step u_step (
		.settings  (settings_q),
		.crc       (crc_q),
		.data_byte (data_byte_s1),
		.crc_next  (crc_next)
	);

	always_comb begin
		cfg_settings = vwch_decode(cfg_data);
		adv_s1       = valid_s1 && (!last_s1 || !out_valid_q || hash.ready);
		crc_upd      = present_s1 ? crc_next : crc_q;
	end

	assign msg.ready      = !valid_s1 || adv_s1;
	assign hash.valid     = out_valid_q;
	assign hash.hash_high = hash_q[63:32];
	assign hash.hash_low  = hash_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_byte_s1 <= msg.data_byte;
			present_s1   <= msg.byte_present;
			last_s1      <= msg.last;
		end
	end

	// Width write reloads the seed; otherwise advance on each transaction, and reseed after a last item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings_q <= RESET_SETTINGS;
			crc_q      <= CRC_SEED;
		end else if (cfg_write) begin
			settings_q <= cfg_settings;
			crc_q      <= CRC_SEED & cfg_settings.mask;
		end else if (adv_s1) begin
			crc_q <= last_s1 ? (CRC_SEED & settings_q.mask) : crc_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (hash.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			hash_q <= crc_upd;
		end
	end

	`VWCH_ASSERT_NOW(a_crc_masked, 1'b1, (crc_q & ~settings_q.mask) == '0)
	`VWCH_ASSERT_NOW(a_stall_cause, !msg.ready, valid_s1 && last_s1 && out_valid_q && !hash.ready)
	`VWCH_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(adv_s1 && last_s1))
	`VWCH_ASSERT_NEXT(a_absent_holds, adv_s1 && !present_s1 && !last_s1 && !cfg_write, $stable(crc_q))

endmodule

>>> tb/variable_width_crc_hash_test.sv
// Self-checking testbench for the variable-width CRC hash: random traffic, width sweeps, back-pressure.
module variable_width_crc_hash_test import vwch_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] HASH_SEED      = 64'hFAC4_32B1_0CD5_E44A;
	localparam logic [63:0] HASH_BASE_POLY = 64'h0060_0340_00F0_D50B;
	localparam int          NARROWEST      = 16;
	localparam int          WIDEST         = 64;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          CYCLE_LIMIT    = 300000;
	localparam int          IDLE_PERCENT   = 37;
	localparam int          ITEM_TARGET    = 1500;

	typedef struct packed {
		logic [31:0] high;
		logic [31:0] low;
	} hash_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [HASH_WIDTH_BITS-1:0] cfg_data = '0;

	vwch_msg_if  msg_ch ();
	vwch_hash_if hash_ch ();

	variable_width_crc_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.msg       (msg_ch),
		.hash      (hash_ch)
	);

	// Model state, updated on every accepted transaction and every width write.
	logic [63:0]                crc_state;
	logic [HASH_WIDTH_BITS-1:0] width_setting;
	hash_word_t                 pending_hashes[$];

	int  hash_failures = 0;
	int  items_sent = 0;
	int  cycle_count = 0;
	int  hold_off_cycles = 0;
	bit  sender_idles = 1'b1;
	bit  receiver_idles = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int active_width(input logic [HASH_WIDTH_BITS-1:0] w);
		if (w < NARROWEST) return NARROWEST;
		if (w > WIDEST) return WIDEST;
		return int'(w);
	endfunction

	function automatic logic [63:0] width_mask(input int n);
		if (n >= WIDEST) return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [63:0] width_poly(input int n);
		if (n >= WIDEST) return HASH_BASE_POLY;
		return (HASH_BASE_POLY >> (WIDEST - n)) | 64'd1;
	endfunction

	function automatic logic [63:0] seed_for(input logic [HASH_WIDTH_BITS-1:0] w);
		return HASH_SEED & width_mask(active_width(w));
	endfunction

	// Fold one byte into the CRC: top byte selects the entry, shift in the new byte.
	function automatic logic [63:0] crc_add_byte(input logic [63:0] crc, input logic [7:0] data,
		input int n);
		logic [7:0]  sel;
		logic [63:0] poly;
		logic [63:0] entry;
		sel = 8'((crc >> (n - 8)) & 64'hFF);
		poly = width_poly(n);
		entry = '0;
		for (int j = 0; j < 8; j++) begin
			entry = entry << 1;
			if (sel[7 - j]) entry = entry ^ poly;
		end
		return ((crc << 8) ^ {56'd0, data} ^ entry) & width_mask(n);
	endfunction

	function automatic void absorb_item(input logic [7:0] data, input logic present,
		input logic is_last);
		hash_word_t word;
		if (present) crc_state = crc_add_byte(crc_state, data, active_width(width_setting));
		if (is_last) begin
			word.high = crc_state[63:32];
			word.low = crc_state[31:0];
			pending_hashes.push_back(word);
			crc_state = seed_for(width_setting);
		end
	endfunction

	function automatic void report_hash_error(input string what, input hash_word_t want,
		input hash_word_t got);
		hash_failures++;
		if (hash_failures <= 10)
			$display("[%0t] hash %s: expected %08h_%08h, got %08h_%08h", $realtime, what,
				want.high, want.low, got.high, got.low);
	endfunction

	always @(posedge clk) begin : check_hashes
		hash_word_t want;
		hash_word_t got;
		if (arst_n && hash_ch.valid && hash_ch.ready) begin
			got.high = hash_ch.hash_high;
			got.low = hash_ch.hash_low;
			if (pending_hashes.size() == 0) begin
				report_hash_error("with none pending", '0, got);
			end else begin
				want = pending_hashes.pop_front();
				if (got.high !== want.high || got.low !== want.low)
					report_hash_error("mismatch", want, got);
			end
		end
	end

	// Receiver: long hold-off when requested, otherwise random stalls if receiver_idles is set.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hash_ch.ready <= 1'b0;
			hold_off_cycles--;
		end else if (receiver_idles && $urandom_range(99) < IDLE_PERCENT) begin
			hash_ch.ready <= 1'b0;
		end else begin
			hash_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** variable_width_crc_hash: FAILED **");
			$finish;
		end
	end

	// Offer one item and hold it until the transaction completes.
	task automatic send_item(input logic [7:0] data, input logic present, input logic is_last);
		if (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data_byte <= data;
		msg_ch.byte_present <= present;
		msg_ch.last <= is_last;
		do @(posedge clk); while (!msg_ch.ready);
		absorb_item(data, present, is_last);
		if (present || is_last) items_sent++;
	endtask

	// Random message; optional absent bytes inside and an absent end marker.
	task automatic send_message(input int len, input bit with_noise);
		if (len == 0) begin
			send_item(8'($urandom), 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if (with_noise && $urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			if (i == len - 1 && $urandom_range(7) == 0) begin
				send_item(8'($urandom), 1'b1, 1'b0);
				send_item(8'($urandom), 1'b0, 1'b1);
			end else begin
				send_item(8'($urandom), 1'b1, i == len - 1);
			end
		end
	endtask

	// Drop valid, wait for every hash, then let non-final bytes clear the pipeline.
	task automatic settle_block();
		msg_ch.valid <= 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hash_width(input logic [HASH_WIDTH_BITS-1:0] w);
		settle_block();
		cfg_write <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_setting = w;
		crc_state = seed_for(w);
	endtask

	task automatic test_reset_seed();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hA5, 1'b1, 1'b1);
	endtask

	task automatic test_item_kinds();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
	endtask

	task automatic test_width_extremes();
		logic [HASH_WIDTH_BITS-1:0] widths[6] = '{7'd16, 7'd64, 7'd15, 7'd65, 7'd0, 7'd127};
		foreach (widths[k]) begin
			write_hash_width(widths[k]);
			send_item(8'h00, 1'b0, 1'b1);
			send_item(8'hFF, 1'b1, 1'b0);
			send_item(8'h00, 1'b1, 1'b1);
		end
	endtask

	task automatic test_abandon_on_write();
		write_hash_width(7'd40);
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		send_item(8'h56, 1'b1, 1'b0);
		write_hash_width(7'd24);
		send_item(8'h78, 1'b1, 1'b1);
	endtask

	task automatic test_back_pressure();
		write_hash_width(7'd32);
		sender_idles = 1'b0;
		hold_off_cycles = 300;
		repeat (60) send_message($urandom_range(2), 1'b0);
		sender_idles = 1'b1;
	endtask

	task automatic test_steady_stream();
		write_hash_width(7'd56);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (40) send_message($urandom_range(8), 1'b0);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [HASH_WIDTH_BITS-1:0] widths[8] =
			'{7'd17, 7'd63, 7'd32, 7'd33, 7'd24, 7'd48, 7'd64, 7'd16};
		int phase;
		int phase_end;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			write_hash_width(phase < 8 ? widths[phase] : HASH_WIDTH_BITS'($urandom_range(127)));
			phase_end = items_sent + 100;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				if ($urandom_range(9) == 0) send_message($urandom_range(40), 1'b1);
				else send_message($urandom_range(8), $urandom_range(3) == 0);
			end
			phase++;
		end
	endtask

	initial begin
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.byte_present = 1'b0;
		msg_ch.last = 1'b0;
		hash_ch.ready = 1'b0;
		width_setting = 7'd64;
		crc_state = seed_for(7'd64);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_item_kinds();
		test_width_extremes();
		test_abandon_on_write();
		test_back_pressure();
		test_steady_stream();
		test_random_traffic();

		settle_block();
		if (hash_failures == 0)
			$display("** variable_width_crc_hash: PASSED **");
		else
			$display("** variable_width_crc_hash: FAILED **");
		$finish;
	end

endmodule
